// ===== hdl/flmm_pkg.sv =====
package flmm_pkg;

    // buffer geometry
    localparam int BUF_DEPTH = 256;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = IDX_W + 1;

    // result field widths
    localparam int START_W = 8;
    localparam int LEN_W   = 9;

    // dfa geometry
    localparam int NUM_ST = 9;
    localparam int ST_W   = $clog2(NUM_ST);
    localparam logic [ST_W-1:0] DFA_START = ST_W'(0);
    localparam logic [ST_W-1:0] DFA_DEAD  = ST_W'(5);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_FETCH  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CLS_DIGIT = 3'd0,
        CLS_DOT   = 3'd1,
        CLS_EXP   = 3'd2,
        CLS_SIGN  = 3'd3,
        CLS_BAD   = 3'd4
    } cls_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_SCAN
    } seq_state_t;

    // store write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

    // one result item
    typedef struct packed {
        logic               overflow;
        logic [LEN_W-1:0]   token_length;
        logic [START_W-1:0] token_start;
        logic               found;
    } result_t;

    // transition table, rows are states, columns are digit, dot, exponent, sign
    localparam logic [ST_W-1:0] NEXT_TAB [NUM_ST][4] = '{
        '{ST_W'(6), ST_W'(2), ST_W'(5), ST_W'(1)},
        '{ST_W'(6), ST_W'(2), ST_W'(5), ST_W'(5)},
        '{ST_W'(7), ST_W'(5), ST_W'(5), ST_W'(5)},
        '{ST_W'(8), ST_W'(5), ST_W'(5), ST_W'(4)},
        '{ST_W'(8), ST_W'(5), ST_W'(5), ST_W'(5)},
        '{ST_W'(5), ST_W'(5), ST_W'(5), ST_W'(5)},
        '{ST_W'(6), ST_W'(7), ST_W'(3), ST_W'(5)},
        '{ST_W'(7), ST_W'(5), ST_W'(3), ST_W'(5)},
        '{ST_W'(8), ST_W'(5), ST_W'(5), ST_W'(5)}
    };

    function automatic cls_t char_class(input logic [7:0] c);
        cls_t cls;
        case (c) inside
            [8'h30:8'h39]: cls = CLS_DIGIT;
            8'h2e:         cls = CLS_DOT;
            8'h65, 8'h45:  cls = CLS_EXP;
            8'h2b, 8'h2d:  cls = CLS_SIGN;
            default:       cls = CLS_BAD;
        endcase
        return cls;
    endfunction

    function automatic logic [ST_W-1:0] dfa_next(input logic [ST_W-1:0] st, input cls_t cls);
        logic [ST_W-1:0] ns;
        if (cls == CLS_BAD || st >= ST_W'(NUM_ST))
            ns = DFA_DEAD;
        else
            ns = NEXT_TAB[st][cls[1:0]];
        return ns;
    endfunction

    function automatic logic dfa_accept(input logic [ST_W-1:0] st);
        return (st == ST_W'(6)) || (st == ST_W'(7)) || (st == ST_W'(8));
    endfunction

endpackage

// ===== hdl/float_literal_maximal_munch_lexer.sv =====
// append, clear and unused op give no item; fetch gives one item
// fetch steps the dfa over the buffer from the cursor, rescanning after each
// failed start and skipping that start, then reports the longest match or the
// end of the buffer; the scan uses the single dfa unit and the store read port
// one item at a time; a finished result waits in an output register
// reset: asynchronous active low, empties the buffer and clears cursor and overflow
module float_literal_maximal_munch_lexer
    import flmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // op[1:0], ch[9:2], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // found[0], token_start[8:1], token_length[17:9], overflow[18]
);

    mem_wr_t          wr;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             emit;
    logic             out_free;
    result_t          res;
    result_t          res_reg;
    logic             out_valid_reg, out_valid_next;

    flmm_char_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    flmm_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .op       (op_t'(s_tdata[1:0])),
        .ch       (s_tdata[9:2]),
        .in_ready (s_tready),
        .out_free (out_free),
        .emit     (emit),
        .res      (res),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg};

endmodule

// ===== hdl/flmm_char_store.sv =====
module flmm_char_store
    import flmm_pkg::*;
(
    input  logic             clk,
    input  mem_wr_t          wr,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/flmm_scan.sv =====
module flmm_scan
    import flmm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  op_t              op,
    input  logic [7:0]       ch,
    output logic             in_ready,
    input  logic             out_free,
    output logic             emit,
    output result_t          res,
    output mem_wr_t          wr,
    output logic [IDX_W-1:0] rd_addr,
    input  logic [7:0]       rd_data
);

    seq_state_t      state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] p_reg, p_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] best_reg, best_next;

    cls_t            cls;
    logic [ST_W-1:0] ns;
    logic            advance;
    logic            accepted;

    // one dfa step on the character at the scan pointer
    assign cls      = char_class(rd_data);
    assign ns       = dfa_next(st_reg, cls);
    assign advance  = (p_reg < fill_reg) && (ns != DFA_DEAD);
    assign accepted = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (accepted && op == OP_FETCH)
                    state_next = SEQ_SCAN;
            end
            SEQ_SCAN:
            begin
                if (!advance && out_free &&
                    (best_reg != '0 || cursor_reg >= fill_reg))
                    state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        fill_next    = fill_reg;
        cursor_next  = cursor_reg;
        dropped_next = dropped_reg;
        p_next       = p_reg;
        st_next      = st_reg;
        cnt_next     = cnt_reg;
        best_next    = best_reg;
        in_ready     = 1'b0;
        emit         = 1'b0;
        res          = '0;
        wr.en        = 1'b0;
        wr.addr      = fill_reg[IDX_W-1:0];
        wr.data      = ch;
        case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (accepted)
                begin
                    case (op)
                        OP_APPEND:
                        begin
                            if (fill_reg < CNT_W'(BUF_DEPTH))
                            begin
                                wr.en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            fill_next    = '0;
                            cursor_next  = '0;
                            dropped_next = 1'b0;
                        end
                        OP_FETCH:
                        begin
                            p_next    = cursor_reg;
                            st_next   = DFA_START;
                            cnt_next  = '0;
                            best_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            SEQ_SCAN:
            begin
                res.overflow = dropped_reg;
                if (advance)
                begin
                    // extend the match by one character
                    st_next  = ns;
                    cnt_next = cnt_reg + 1'b1;
                    p_next   = p_reg + 1'b1;
                    if (dfa_accept(ns))
                        best_next = cnt_reg + 1'b1;
                end
                else if (best_reg != '0)
                begin
                    // longest match found, report and step past it
                    if (out_free)
                    begin
                        emit             = 1'b1;
                        res.found        = 1'b1;
                        res.token_start  = START_W'(cursor_reg);
                        res.token_length = best_reg;
                        cursor_next      = cursor_reg + CNT_W'(best_reg);
                    end
                end
                else if (cursor_reg >= fill_reg)
                begin
                    // buffer exhausted
                    emit = out_free;
                end
                else
                begin
                    // no match here, skip one character and retry
                    cursor_next = cursor_reg + 1'b1;
                    p_next      = cursor_reg + 1'b1;
                    st_next     = DFA_START;
                    cnt_next    = '0;
                    best_next   = '0;
                end
            end
            default: ;
        endcase
    end

    // read ahead so the character at the next pointer arrives with it
    assign rd_addr = p_next[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_IDLE;
            fill_reg    <= '0;
            cursor_reg  <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cursor_reg  <= cursor_next;
            dropped_reg <= dropped_next;
        end
    end

    // scan working registers
    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        st_reg   <= st_next;
        cnt_reg  <= cnt_next;
        best_reg <= best_next;
    end

endmodule

// ===== test/float_literal_maximal_munch_lexer_tb.sv =====
module float_literal_maximal_munch_lexer_tb;
    import flmm_pkg::*;

    localparam int unsigned ITEM_TARGET = 1100;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned SETTLE_CYCLES = 100;

    typedef logic [7:0] byte_q_t [$];

    // lexer state mirror and queue of predicted token replies
    class lexer_scoreboard;
        localparam int unsigned DEAD_STATE = 5;

        logic [7:0]  chars [BUF_DEPTH];
        int unsigned fill_cnt;
        int unsigned cursor;
        bit          dropped;
        result_t     expected_q [$];
        int unsigned errors;
        int unsigned tokens;
        int unsigned exhausted;
        int unsigned ovf_replies;
        int unsigned dropped_chars;

        function new();
            fill_cnt      = 0;
            cursor        = 0;
            dropped       = 1'b0;
            errors        = 0;
            tokens        = 0;
            exhausted     = 0;
            ovf_replies   = 0;
            dropped_chars = 0;
        endfunction

        function cls_t classify(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return CLS_DIGIT;
            if (c == ".")
                return CLS_DOT;
            if (c == "e" || c == "E")
                return CLS_EXP;
            if (c == "+" || c == "-")
                return CLS_SIGN;
            return CLS_BAD;
        endfunction

        // literal automaton, columns are digit, dot, exponent, sign
        function int unsigned advance(int unsigned st, cls_t c);
            int unsigned row [4];
            case (st)
                0:       row = '{6, 2, 5, 1};
                1:       row = '{6, 2, 5, 5};
                2:       row = '{7, 5, 5, 5};
                3:       row = '{8, 5, 5, 4};
                4:       row = '{8, 5, 5, 5};
                6:       row = '{6, 7, 3, 5};
                7:       row = '{7, 5, 3, 5};
                8:       row = '{8, 5, 5, 5};
                default: row = '{5, 5, 5, 5};
            endcase
            if (c == CLS_BAD)
                return DEAD_STATE;
            return row[int'(c)];
        endfunction

        // longest literal starting at a given index, zero if none
        function int unsigned longest_match(int unsigned from);
            int unsigned st;
            int unsigned best;
            int unsigned p;
            st   = 0;
            best = 0;
            p    = from;
            while (p < fill_cnt)
            begin
                st = advance(st, classify(chars[p]));
                if (st == DEAD_STATE)
                    break;
                if (st >= 6)
                    best = p - from + 1;
                p++;
            end
            return best;
        endfunction

        function void note_input(op_t op, logic [7:0] ch);
            result_t     r;
            int unsigned len;
            case (op)
                OP_APPEND:
                begin
                    if (fill_cnt < BUF_DEPTH)
                    begin
                        chars[fill_cnt] = ch;
                        fill_cnt++;
                    end
                    else
                    begin
                        dropped = 1'b1;
                        dropped_chars++;
                    end
                end
                OP_CLEAR:
                begin
                    fill_cnt = 0;
                    cursor   = 0;
                    dropped  = 1'b0;
                end
                OP_FETCH:
                begin
                    r   = '0;
                    len = 0;
                    // skip failed starts until a literal or the end of the buffer
                    while (cursor < fill_cnt && len == 0)
                    begin
                        len = longest_match(cursor);
                        if (len == 0)
                            cursor++;
                    end
                    if (len != 0)
                    begin
                        r.found        = 1'b1;
                        r.token_start  = START_W'(cursor);
                        r.token_length = LEN_W'(len);
                        cursor += len;
                        tokens++;
                    end
                    else
                        exhausted++;
                    r.overflow = dropped;
                    if (dropped)
                        ovf_replies++;
                    expected_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            errors++;
            $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_result(logic [23:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[18:0]);
            if (expected_q.size() == 0)
            begin
                report("unexpected item", 32'(data), 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.found != want.found)
                report("found", 32'(got.found), 32'(want.found));
            if (got.token_start != want.token_start)
                report("token_start", 32'(got.token_start), 32'(want.token_start));
            if (got.token_length != want.token_length)
                report("token_length", 32'(got.token_length), 32'(want.token_length));
            if (got.overflow != want.overflow)
                report("overflow", 32'(got.overflow), 32'(want.overflow));
        endtask

        task check_leftovers();
            if (expected_q.size() != 0)
                report("items never delivered", expected_q.size(), 0);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    lexer_scoreboard sb = new();
    int unsigned     items_sent = 0;
    int unsigned     cycle_cnt = 0;
    bit              calm_send = 1'b0;
    bit              calm_recv = 1'b0;

    float_literal_maximal_munch_lexer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver back-pressure
    initial
    begin
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (calm_recv)
            begin
                m_tready <= 1'b1;
                hold = 0;
            end
            else if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                hold = pick_gap();
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] pick_char(cls_t c);
        logic [7:0] junk [10];
        junk = '{8'h00, 8'h20, 8'h2c, 8'h61, 8'h2f, 8'h3a, 8'h7f, 8'h80, 8'hff,
                 8'($urandom_range(0, 255))};
        case (c)
            CLS_DIGIT: return 8'h30 + 8'($urandom_range(0, 9));
            CLS_DOT:   return ".";
            CLS_EXP:   return $urandom_range(0, 1) ? "e" : "E";
            CLS_SIGN:  return $urandom_range(0, 1) ? "+" : "-";
            default:   return junk[$urandom_range(0, 9)];
        endcase
    endfunction

    // mostly well-formed literals, some broken runs and raw bytes
    function automatic byte_q_t make_fragment();
        byte_q_t     q;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            if ($urandom_range(0, 2) == 0)
                q.push_back(pick_char(CLS_SIGN));
            repeat ($urandom_range(0, 4))
                q.push_back(pick_char(CLS_DIGIT));
            if ($urandom_range(0, 1))
            begin
                q.push_back(pick_char(CLS_DOT));
                repeat ($urandom_range(0, 3))
                    q.push_back(pick_char(CLS_DIGIT));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                q.push_back(pick_char(CLS_EXP));
                if ($urandom_range(0, 1))
                    q.push_back(pick_char(CLS_SIGN));
                repeat ($urandom_range(0, 3))
                    q.push_back(pick_char(CLS_DIGIT));
            end
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 6))
                q.push_back(pick_char(cls_t'($urandom_range(0, 3))));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                q.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) < 7)
            q.push_back(pick_char(CLS_BAD));
        return q;
    endfunction

    // one item on the slave side, returns at the accepting edge
    task automatic send_item(op_t op, logic [7:0] ch);
        int unsigned gap;
        gap = calm_send ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, ch, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(op, ch);
        items_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_item(OP_APPEND, s[i]);
    endtask

    task automatic fetch_until_empty();
        while (sb.cursor < sb.fill_cnt)
            send_item(OP_FETCH, 8'($urandom_range(0, 255)));
        send_item(OP_FETCH, 8'($urandom_range(0, 255)));
    endtask

    // hold off the sender until every reply is in
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    initial
    begin
        byte_q_t frag;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: signed exponent, zero byte, leading dot, upper-case exponent,
        // trailing dot, dangling exponent sign, unused op
        send_item(OP_CLEAR, 8'hff);
        send_text("+1.5e-3");
        send_item(OP_APPEND, 8'h00);
        send_text(".5E1.e+-7");
        send_item(OP_NONE, 8'h35);
        repeat (6)
            send_item(OP_FETCH, 8'h00);
        wait_for_results();

        // full buffer of digits: longest possible token and dropped characters
        calm_send = 1'b1;
        calm_recv = 1'b1;
        send_item(OP_CLEAR, 8'h00);
        repeat (BUF_DEPTH + 2)
            send_item(OP_APPEND, pick_char(CLS_DIGIT));
        fetch_until_empty();

        // full buffer of mixed text, last token in the final slot
        calm_send = 1'b0;
        calm_recv = 1'b0;
        send_item(OP_CLEAR, 8'h5a);
        while (sb.fill_cnt < BUF_DEPTH - 2)
        begin
            frag = make_fragment();
            foreach (frag[i])
                if (sb.fill_cnt < BUF_DEPTH - 2)
                    send_item(OP_APPEND, frag[i]);
        end
        send_item(OP_APPEND, 8'h20);
        send_item(OP_APPEND, "7");
        send_item(OP_APPEND, "9");
        fetch_until_empty();

        // random runs of literals and noise with fetches mixed in
        while (items_sent < ITEM_TARGET)
        begin
            calm_send = ($urandom_range(0, 4) == 0);
            calm_recv = ($urandom_range(0, 4) == 0);
            if (sb.fill_cnt > 200 || $urandom_range(0, 3) != 0)
                send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 8))
            begin
                frag = make_fragment();
                foreach (frag[i])
                    send_item(OP_APPEND, frag[i]);
                if ($urandom_range(0, 9) < 4)
                    send_item(OP_FETCH, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_NONE, 8'($urandom_range(0, 255)));
            end
            fetch_until_empty();
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.check_leftovers();
        $display("%0d items sent: %0d tokens, %0d end-of-buffer replies, %0d with overflow",
                 items_sent, sb.tokens, sb.exhausted, sb.ovf_replies);
        $display("%0d characters refused on a full buffer, %0d mismatches",
                 sb.dropped_chars, sb.errors);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
